// ----- hdl/three_level_ready_queue_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the three-level ready queue scheduler
// Shared helpers for the concurrent checks on the scheduler ports.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define THREE_LEVEL_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define TLRQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Plain condition checked on every clock edge outside reset.
`define TLRQ_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

`endif

// ----- hdl/tlrq_pkg.sv -----
// ----------------------------------------------------------------------------
// Ready queue scheduler package
// Types, constants and helper functions shared by the scheduler modules.
// ----------------------------------------------------------------------------
package tlrq_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam logic [7:0] PRIO_CAP = 8'd149;
    localparam logic [7:0] L1_FLOOR = 8'd100;
    localparam logic [7:0] L2_FLOOR = 8'd50;
    localparam logic [15:0] THR_RESET = 16'd1500;
    localparam logic [5:0] STEP_RESET = 6'd10;

    localparam logic CFG_AGING_THR = 1'b0;
    localparam logic CFG_AGING_STEP = 1'b1;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        LVL_ONE = 2'd0,
        LVL_TWO = 2'd1,
        LVL_THREE = 2'd2
    } t_level;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AGE,
        S_SWEEP,
        S_FIX,
        S_PASS,
        S_DONE
    } t_state;

    typedef struct packed {
        logic age;
        logic sweep;
        logic fix;
        logic clr;
        logic pass;
        logic rm;
    } t_cell_ctrl;

    function automatic logic [1:0] band(input logic [7:0] p);
        logic [1:0] b;
        if (p >= L1_FLOOR) begin
            b = LVL_ONE;
        end else if (p >= L2_FLOOR) begin
            b = LVL_TWO;
        end else begin
            b = LVL_THREE;
        end
        return b;
    endfunction

endpackage

// ----- hdl/three_level_ready_queue_scheduler.sv -----
// ----------------------------------------------------------------------------
// Three-level ready queue scheduler
// Task ready queue with three service bands, preemption hints and aging.
// ----------------------------------------------------------------------------
// An enqueue's result beat is ready on the next cycle.
// A dequeue steps through its states in order: one state ages every slot at
// once, a sweep walks the arrival ranks of the waiting tasks to move aged
// third-level tasks to the tail, and a pass lets the best candidate travel
// down the row of slot cells, one cell a cycle.
// A new beat is taken once the previous one has finished and its result has
// left, or is leaving, the output register.
module three_level_ready_queue_scheduler #(
    parameter int MAX_TASKS = tlrq_pkg::MAX_TASKS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation, task_id, task_priority, task_burst, now_tick,
    // running_priority, running_burst, running_start, zero fill
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // found, chosen_id, chosen_level, preempt_request, burst_update_valid,
    // remaining_burst, overflow, zero fill
    output logic [31:0]  m_axis_tdata
);
    import tlrq_pkg::*;

    localparam int OW = $clog2(MAX_TASKS) + 1;
    localparam int IW = $clog2(MAX_TASKS);

    t_state        r_state, n_state;
    logic [15:0]   r_thr;
    logic [5:0]    r_step;
    logic [OW-1:0] r_cnt;
    logic [OW-1:0] r_step_cnt;
    logic [OW-1:0] r_tail_cnt;
    logic [31:0]   r_now;
    logic          r_out_vld;
    logic [31:0]   r_out;
    logic [31:0]   n_out;

    logic        in_op;
    logic [7:0]  in_id;
    logic [7:0]  in_prio_raw;
    logic [7:0]  in_prio;
    logic [15:0] in_burst;
    logic [31:0] in_now;
    logic [7:0]  in_rprio;
    logic [15:0] in_rburst;
    logic [31:0] in_rstart;

    logic        accept;
    logic        enq;
    logic        out_free;
    logic [31:0] elapsed;
    logic [15:0] rem;
    logic        enq_pre;
    logic        enq_buv;
    logic        any_tail;

    t_cell_ctrl ctrl;
    logic [MAX_TASKS:0]   free_seen;
    logic [MAX_TASKS-1:0] cell_vld;
    logic [MAX_TASKS-1:0] cell_wr;
    logic [MAX_TASKS-1:0] cell_hit;

    logic          tok_vld   [MAX_TASKS+1];
    logic [1:0]    tok_lvl   [MAX_TASKS+1];
    logic [15:0]   tok_burst [MAX_TASKS+1];
    logic [7:0]    tok_prio  [MAX_TASKS+1];
    logic [7:0]    tok_id    [MAX_TASKS+1];
    logic [OW-1:0] tok_order [MAX_TASKS+1];
    logic [IW-1:0] tok_idx   [MAX_TASKS+1];

    assign in_op = s_axis_tdata[0];
    assign in_id = s_axis_tdata[8:1];
    assign in_prio_raw = s_axis_tdata[16:9];
    assign in_burst = s_axis_tdata[32:17];
    assign in_now = s_axis_tdata[64:33];
    assign in_rprio = s_axis_tdata[72:65];
    assign in_rburst = s_axis_tdata[88:73];
    assign in_rstart = s_axis_tdata[120:89];
    assign in_prio = (in_prio_raw > PRIO_CAP) ? PRIO_CAP : in_prio_raw;

    assign out_free = !r_out_vld || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign enq = accept && (in_op == OP_ENQ) && free_seen[MAX_TASKS];

    assign elapsed = in_now - in_rstart;
    assign rem = (elapsed <= {16'd0, in_rburst}) ? (in_rburst - elapsed[15:0]) : 16'd0;

    always_comb begin
        enq_pre = 1'b0;
        enq_buv = 1'b0;
        case (band(in_prio))
            LVL_ONE: begin
                enq_buv = in_burst < rem;
                enq_pre = enq_buv;
            end
            LVL_TWO: begin
                enq_pre = in_prio > in_rprio;
            end
            default: begin
                enq_pre = 1'b0;
            end
        endcase
    end

    assign free_seen[0] = 1'b0;
    assign tok_vld[0] = 1'b0;
    assign tok_lvl[0] = LVL_THREE;
    assign tok_burst[0] = '0;
    assign tok_prio[0] = '0;
    assign tok_id[0] = '0;
    assign tok_order[0] = '0;
    assign tok_idx[0] = '0;
    assign any_tail = |cell_hit;

    always_comb begin
        ctrl = '0;
        ctrl.age = (r_state == S_AGE);
        ctrl.sweep = (r_state == S_SWEEP) && (r_step_cnt != r_cnt);
        ctrl.fix = (r_state == S_FIX);
        ctrl.clr = (r_state == S_FIX);
        ctrl.pass = (r_state == S_PASS);
        ctrl.rm = (r_state == S_DONE) && out_free && tok_vld[MAX_TASKS];
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        assign free_seen[g+1] = free_seen[g] | !cell_vld[g];
        assign cell_wr[g] = accept && (in_op == OP_ENQ) && !cell_vld[g] && !free_seen[g];

        tlrq_cell #(
            .MAX_TASKS(MAX_TASKS),
            .IDX(g)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl(ctrl),
            .i_wr(cell_wr[g]),
            .i_id(in_id),
            .i_prio(in_prio),
            .i_burst(in_burst),
            .i_now(ctrl.age ? r_now : in_now),
            .i_thr(r_thr),
            .i_step(r_step),
            .i_cnt(r_cnt),
            .i_sweep_r(r_step_cnt),
            .i_sweep_c(r_tail_cnt),
            .i_fix_t(r_tail_cnt),
            .i_rm_idx(tok_idx[MAX_TASKS]),
            .i_rm_order(tok_order[MAX_TASKS]),
            .i_tok_vld(tok_vld[g]),
            .i_tok_lvl(tok_lvl[g]),
            .i_tok_burst(tok_burst[g]),
            .i_tok_prio(tok_prio[g]),
            .i_tok_id(tok_id[g]),
            .i_tok_order(tok_order[g]),
            .i_tok_idx(tok_idx[g]),
            .o_tok_vld(tok_vld[g+1]),
            .o_tok_lvl(tok_lvl[g+1]),
            .o_tok_burst(tok_burst[g+1]),
            .o_tok_prio(tok_prio[g+1]),
            .o_tok_id(tok_id[g+1]),
            .o_tok_order(tok_order[g+1]),
            .o_tok_idx(tok_idx[g+1]),
            .o_valid(cell_vld[g]),
            .o_hit_tail(cell_hit[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (in_op == OP_DEQ)) begin
                    n_state = S_AGE;
                end
            end
            S_AGE: begin
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (r_step_cnt == r_cnt) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_state = S_PASS;
            end
            S_PASS: begin
                if (r_step_cnt == OW'(MAX_TASKS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_thr <= THR_RESET;
            r_step <= STEP_RESET;
            r_cnt <= '0;
            r_step_cnt <= '0;
            r_tail_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AGING_THR: r_thr <= i_cfg_wdata;
                    CFG_AGING_STEP: r_step <= i_cfg_wdata[5:0];
                    default: r_thr <= r_thr;
                endcase
            end
            if ((accept && (in_op == OP_ENQ)) || ((r_state == S_DONE) && out_free)) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (enq) begin
                r_cnt <= r_cnt + 1'b1;
            end
            case (r_state)
                S_AGE: begin
                    r_step_cnt <= '0;
                    r_tail_cnt <= '0;
                end
                S_SWEEP: begin
                    if (r_step_cnt == r_cnt) begin
                        r_step_cnt <= '0;
                    end else begin
                        r_step_cnt <= r_step_cnt + 1'b1;
                        if (any_tail) begin
                            r_tail_cnt <= r_tail_cnt + 1'b1;
                        end
                    end
                end
                S_PASS: begin
                    r_step_cnt <= r_step_cnt + 1'b1;
                end
                S_DONE: begin
                    if (out_free && tok_vld[MAX_TASKS]) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: begin
                    r_step_cnt <= r_step_cnt;
                end
            endcase
        end
    end

    always_comb begin
        n_out = r_out;
        if (accept && (in_op == OP_ENQ)) begin
            n_out = '0;
            if (!free_seen[MAX_TASKS]) begin
                n_out[29] = 1'b1;
            end else begin
                n_out[11] = enq_pre;
                n_out[12] = enq_buv;
                n_out[28:13] = enq_buv ? rem : 16'd0;
            end
        end else if ((r_state == S_DONE) && out_free) begin
            n_out = '0;
            if (tok_vld[MAX_TASKS]) begin
                n_out[0] = 1'b1;
                n_out[8:1] = tok_id[MAX_TASKS];
                n_out[10:9] = tok_lvl[MAX_TASKS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (in_op == OP_DEQ)) begin
            r_now <= in_now;
        end
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata = r_out;

endmodule

// ----- hdl/tlrq_cell.sv -----
// ----------------------------------------------------------------------------
// Ready queue cell
// Holds one table slot, ages it, re-ranks it and passes the best candidate on.
// ----------------------------------------------------------------------------
module tlrq_cell #(
    parameter int MAX_TASKS = 16,
    parameter int IDX = 0,
    localparam int OW = $clog2(MAX_TASKS) + 1,
    localparam int IW = $clog2(MAX_TASKS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlrq_pkg::t_cell_ctrl i_ctrl,
    input  logic                 i_wr,
    input  logic [7:0]           i_id,
    input  logic [7:0]           i_prio,
    input  logic [15:0]          i_burst,
    input  logic [31:0]          i_now,
    input  logic [15:0]          i_thr,
    input  logic [5:0]           i_step,
    input  logic [OW-1:0]        i_cnt,
    input  logic [OW-1:0]        i_sweep_r,
    input  logic [OW-1:0]        i_sweep_c,
    input  logic [OW-1:0]        i_fix_t,
    input  logic [IW-1:0]        i_rm_idx,
    input  logic [OW-1:0]        i_rm_order,
    input  logic                 i_tok_vld,
    input  logic [1:0]           i_tok_lvl,
    input  logic [15:0]          i_tok_burst,
    input  logic [7:0]           i_tok_prio,
    input  logic [7:0]           i_tok_id,
    input  logic [OW-1:0]        i_tok_order,
    input  logic [IW-1:0]        i_tok_idx,
    output logic                 o_tok_vld,
    output logic [1:0]           o_tok_lvl,
    output logic [15:0]          o_tok_burst,
    output logic [7:0]           o_tok_prio,
    output logic [7:0]           o_tok_id,
    output logic [OW-1:0]        o_tok_order,
    output logic [IW-1:0]        o_tok_idx,
    output logic                 o_valid,
    output logic                 o_hit_tail
);
    import tlrq_pkg::*;

    logic          r_valid;
    logic          r_tail;
    logic [7:0]    r_id;
    logic [7:0]    r_prio;
    logic [15:0]   r_burst;
    logic [31:0]   r_ready;
    logic [OW-1:0] r_order;

    logic [31:0] wait_ticks;
    logic        do_age;
    logic [8:0]  prio_sum;
    logic [7:0]  prio_new;
    logic [1:0]  own_lvl;
    logic        tie_order;
    logic        better;
    logic        sweep_hit;

    assign wait_ticks = i_now - r_ready;
    assign do_age = r_valid && (wait_ticks >= {16'd0, i_thr});
    assign prio_sum = {1'b0, r_prio} + {3'd0, i_step};
    assign prio_new = (prio_sum > {1'b0, PRIO_CAP}) ? PRIO_CAP : prio_sum[7:0];
    assign own_lvl = band(r_prio);
    assign sweep_hit = r_valid && (r_order == i_sweep_r);
    assign o_hit_tail = i_ctrl.sweep && sweep_hit && r_tail;
    assign o_valid = r_valid;

    always_comb begin
        tie_order = (r_id < i_tok_id) || ((r_id == i_tok_id) && (r_order < i_tok_order));
        better = 1'b0;
        if (r_valid) begin
            if (!i_tok_vld || (own_lvl < i_tok_lvl)) begin
                better = 1'b1;
            end else if (own_lvl == i_tok_lvl) begin
                case (own_lvl)
                    LVL_ONE: begin
                        better = (r_burst < i_tok_burst)
                              || ((r_burst == i_tok_burst) && tie_order);
                    end
                    LVL_TWO: begin
                        better = (r_prio > i_tok_prio)
                              || ((r_prio == i_tok_prio) && tie_order);
                    end
                    default: begin
                        better = r_order < i_tok_order;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tail <= 1'b0;
            o_tok_vld <= 1'b0;
        end else begin
            if (i_wr) begin
                r_valid <= 1'b1;
                r_tail <= 1'b0;
                r_id <= i_id;
                r_prio <= i_prio;
                r_burst <= i_burst;
                r_ready <= i_now;
                r_order <= i_cnt;
            end
            if (i_ctrl.age && do_age) begin
                r_prio <= prio_new;
                r_ready <= i_now;
                r_tail <= (band(prio_new) == LVL_THREE);
            end
            if (i_ctrl.sweep && sweep_hit) begin
                r_order <= r_tail ? (i_cnt + i_sweep_c) : (i_sweep_r - i_sweep_c);
            end
            if (i_ctrl.fix) begin
                r_tail <= 1'b0;
                if (r_valid && r_tail) begin
                    r_order <= r_order - i_fix_t;
                end
            end
            if (i_ctrl.rm && r_valid) begin
                if (i_rm_idx == IW'(IDX)) begin
                    r_valid <= 1'b0;
                end else if (r_order > i_rm_order) begin
                    r_order <= r_order - 1'b1;
                end
            end
            if (i_ctrl.clr) begin
                o_tok_vld <= 1'b0;
            end else if (i_ctrl.pass) begin
                o_tok_vld <= better ? 1'b1 : i_tok_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.pass) begin
            if (better) begin
                o_tok_lvl <= own_lvl;
                o_tok_burst <= r_burst;
                o_tok_prio <= r_prio;
                o_tok_id <= r_id;
                o_tok_order <= r_order;
                o_tok_idx <= IW'(IDX);
            end else begin
                o_tok_lvl <= i_tok_lvl;
                o_tok_burst <= i_tok_burst;
                o_tok_prio <= i_tok_prio;
                o_tok_id <= i_tok_id;
                o_tok_order <= i_tok_order;
                o_tok_idx <= i_tok_idx;
            end
        end
    end

endmodule

// ----- hdl/tlrq_checker.sv -----
// ----------------------------------------------------------------------------
// Ready queue scheduler checker
// Port-level checks on the result stream of the scheduler.
// ----------------------------------------------------------------------------
`include "three_level_ready_queue_scheduler_defines.svh"

module tlrq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    `TLRQ_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result beat dropped")
    `TLRQ_CHECK(a_excl, !m_axis_tvalid || !(m_axis_tdata[0] && m_axis_tdata[29]), "found with overflow")
    `TLRQ_CHECK(a_burst, !m_axis_tvalid || !m_axis_tdata[12] || m_axis_tdata[11], "burst without preempt")
    `TLRQ_CHECK(a_empty, !m_axis_tvalid || m_axis_tdata[0] || (m_axis_tdata[10:1] == 10'd0), "stale choice")

endmodule

bind three_level_ready_queue_scheduler tlrq_checker u_tlrq_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
